// ----- rtl/stack_machine_alu_macros.svh -----
// ----------------------------------------------------------------------------
// stack machine alu assertion macros
// Concurrent assertion helpers clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_ALU_MACROS_SVH
`define STACK_MACHINE_ALU_MACROS_SVH
`ifndef ASSERT_OFF
`define SMA_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
`define SMA_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define SMA_ASSERT_IMP(label, pre, post)
`define SMA_ASSERT_NXT(label, pre, post)
`endif
`endif

// ----- rtl/sma_pkg.sv -----
// ----------------------------------------------------------------------------
// sma_pkg
// Opcodes, status and emit codes, and the shared unit request type.
// ----------------------------------------------------------------------------
package sma_pkg;
   localparam logic [3:0] OP_PUSH  = 4'd0;
   localparam logic [3:0] OP_POP   = 4'd1;
   localparam logic [3:0] OP_ROT   = 4'd2;
   localparam logic [3:0] OP_EMITN = 4'd3;
   localparam logic [3:0] OP_EMITC = 4'd4;
   localparam logic [3:0] OP_DUP   = 4'd5;
   localparam logic [3:0] OP_SWAP  = 4'd6;
   localparam logic [3:0] OP_SUB   = 4'd7;
   localparam logic [3:0] OP_ADD   = 4'd8;
   localparam logic [3:0] OP_MUL   = 4'd9;
   localparam logic [3:0] OP_DIV   = 4'd10;
   localparam logic [3:0] OP_REM   = 4'd11;
   localparam logic [3:0] OP_PEEK  = 4'd12;
   localparam logic [3:0] OP_SIZE  = 4'd13;
   localparam logic [3:0] OP_CLEAR = 4'd14;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_NUM  = 2'd1;
   localparam logic [1:0] KIND_CHAR = 2'd2;

   typedef logic [2:0] alu_op_type;
   localparam alu_op_type ALU_SUB = 3'd0;
   localparam alu_op_type ALU_ADD = 3'd1;
   localparam alu_op_type ALU_MUL = 3'd2;
   localparam alu_op_type ALU_DIV = 3'd3;
   localparam alu_op_type ALU_REM = 3'd4;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;
endpackage

// ----- rtl/sma_alu.sv -----
// ----------------------------------------------------------------------------
// sma_alu
// Shared adder stepped by a counter: one pass for add and sub, one bit per
// cycle for shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module sma_alu #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sma_pkg::alu_req_type    req,
   input  logic [WORD_WIDTH-1:0]   opa,
   input  logic [WORD_WIDTH-1:0]   opb,
   output logic                    done,
   output logic [WORD_WIDTH-1:0]   result
);
   import sma_pkg::*;

   localparam int CW = $clog2(WORD_WIDTH + 1);

   logic                  busy_ff, busy_in, done_ff, done_in;
   alu_op_type            op_ff, op_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic [WORD_WIDTH:0]   add_a, add_b, shifted;
   logic                  add_sub;
   logic [WORD_WIDTH+1:0] sum;

   assign shifted = {acc_ff, x_ff[WORD_WIDTH-1]};

   always_comb begin
      add_a   = {1'b0, x_ff};
      add_b   = {1'b0, y_ff};
      add_sub = 1'b0;
      case (op_ff)
         ALU_SUB: add_sub = 1'b1;
         ALU_MUL: begin
            add_a = {1'b0, acc_ff};
            add_b = {1'b0, x_ff};
         end
         ALU_DIV, ALU_REM: begin
            add_a   = shifted;
            add_sub = 1'b1;
         end
         default: ;
      endcase
      sum = {1'b0, add_a} + {1'b0, add_b ^ {(WORD_WIDTH + 1){add_sub}}}
            + (WORD_WIDTH + 2)'(add_sub);
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         acc_in  = '0;
         x_in    = opa;
         y_in    = opb;
         step_in = (req.op == ALU_ADD || req.op == ALU_SUB) ? CW'(1) : CW'(WORD_WIDTH);
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               if (y_ff[0]) acc_in = sum[WORD_WIDTH-1:0];
               x_in = {x_ff[WORD_WIDTH-2:0], 1'b0};
               y_in = {1'b0, y_ff[WORD_WIDTH-1:1]};
            end
            ALU_DIV, ALU_REM: begin
               // carry out means no borrow: the trial subtract is kept
               acc_in = sum[WORD_WIDTH+1] ? sum[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
               x_in   = {x_ff[WORD_WIDTH-2:0], sum[WORD_WIDTH+1]};
            end
            default: acc_in = sum[WORD_WIDTH-1:0];
         endcase
         step_in = step_ff - 1'b1;
         if (step_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == ALU_DIV) ? x_ff : acc_ff;
endmodule

// ----- rtl/stack_machine_alu.sv -----
// ----------------------------------------------------------------------------
// stack_machine_alu
// Bounded word stack with a sequencer and a shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// One word in, one word out. The stack lives in a memory with one write port and
// a registered read port, so every instruction is paced by memory accesses:
// size, clear, underflow and overflow errors and the unused opcode go straight
// to the response, push writes once, the rest read the top words first, the
// arithmetic ops also wait on the shared unit, and rot swaps one pair at a time.
// The input is not ready while an instruction runs; a finished result may
// wait in the output register while the next word is taken.
module stack_machine_alu #(
   parameter int STACK_DEPTH = 256,
   parameter int WORD_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [3:0]                           req_opcode,
   input  logic [WORD_WIDTH-1:0]                req_push_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [WORD_WIDTH-1:0]                rsp_result_value,
   output logic [$clog2(STACK_DEPTH + 1)-1:0]   rsp_stack_depth,
   output logic [1:0]                           rsp_emit_kind,
   output logic [1:0]                           rsp_status
);
   import sma_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int AW    = $clog2(STACK_DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PUSH = 4'd1;
   localparam logic [3:0] S_RD1  = 4'd2;
   localparam logic [3:0] S_RD2  = 4'd3;
   localparam logic [3:0] S_RD3  = 4'd4;
   localparam logic [3:0] S_SWAP = 4'd5;
   localparam logic [3:0] S_EXE  = 4'd6;
   localparam logic [3:0] S_RLO  = 4'd7;
   localparam logic [3:0] S_RHI  = 4'd8;
   localparam logic [3:0] S_WLO  = 4'd9;
   localparam logic [3:0] S_WHI  = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [3:0]            op_ff, op_in;
   logic [WORD_WIDTH-1:0] pv_ff, pv_in, t_ff, t_in, res_ff, res_in;
   logic [1:0]            st_ff, st_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, cnt_m1, cnt_m2;
   logic [AW-1:0]         lo_ff, lo_in, hi_ff, hi_in;

   logic [WORD_WIDTH-1:0] stack_mem_ff [STACK_DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff, wr_data;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic                  wr_en;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_res_ff, rsp_res_in;
   logic [CNT_W-1:0]      rsp_depth_ff, rsp_depth_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in, rsp_st_ff, rsp_st_in;

   alu_req_type           alu_req;
   logic                  alu_done;
   logic [WORD_WIDTH-1:0] alu_result;

   logic                  under_err, over_err, full;

   sma_alu #(.WORD_WIDTH(WORD_WIDTH)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (t_ff),
      .opb    (rd_data_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign cnt_m1    = cnt_ff - 1'b1;
   assign cnt_m2    = cnt_ff - 2'd2;
   assign full      = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      under_err = 1'b0;
      over_err  = 1'b0;
      case (req_opcode) inside
         OP_POP, OP_EMITN, OP_EMITC, OP_PEEK, OP_CLEAR: under_err = (cnt_ff == '0);
         OP_SWAP, OP_SUB, OP_ADD, OP_MUL, OP_DIV, OP_REM: under_err = (cnt_ff < CNT_W'(2));
         OP_DUP: begin
            under_err = (cnt_ff == '0);
            over_err  = full;
         end
         OP_PUSH: over_err = full;
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pv_in         = pv_ff;
      t_in          = t_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rd_addr       = cnt_m1[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = cnt_m1[AW-1:0];
      wr_data       = t_ff;
      alu_req.start = 1'b0;
      alu_req.op    = ALU_ADD;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_res_in    = rsp_res_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_st_in     = rsp_st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               pv_in  = req_push_value;
               res_in = '0;
               st_in  = ST_OK;
               lo_in  = '0;
               hi_in  = cnt_m1[AW-1:0];
               if (under_err) begin
                  st_in    = ST_UNDER;
                  state_in = S_FIN;
               end else if (over_err) begin
                  st_in    = ST_OVER;
                  state_in = S_FIN;
               end else begin
                  case (req_opcode) inside
                     OP_PUSH: state_in = S_PUSH;
                     OP_ROT:  state_in = (cnt_ff < CNT_W'(2)) ? S_FIN : S_RLO;
                     OP_SIZE: begin
                        res_in   = WORD_WIDTH'(cnt_ff);
                        state_in = S_FIN;
                     end
                     OP_POP, OP_EMITN, OP_EMITC, OP_DUP, OP_SWAP, OP_SUB, OP_ADD,
                     OP_MUL, OP_DIV, OP_REM, OP_PEEK: state_in = S_RD1;
                     default: state_in = S_FIN;
                  endcase
               end
            end
         end
         S_PUSH: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_ff[AW-1:0];
            wr_data  = pv_ff;
            state_in = S_FIN;
         end
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            t_in     = rd_data_ff;
            rd_addr  = cnt_m2[AW-1:0];
            state_in = S_RD3;
         end
         S_RD3: begin
            // second word is on the read data now
            state_in = S_FIN;
            case (op_ff) inside
               OP_POP, OP_EMITN, OP_EMITC, OP_PEEK: res_in = t_ff;
               OP_DUP: begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
               end
               OP_SWAP: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data_ff;
                  state_in = S_SWAP;
               end
               OP_SUB, OP_ADD, OP_MUL, OP_DIV, OP_REM: begin
                  if ((op_ff == OP_DIV || op_ff == OP_REM) && rd_data_ff == '0) begin
                     st_in = ST_DIVZ;
                  end else begin
                     alu_req.start = 1'b1;
                     case (op_ff)
                        OP_SUB:  alu_req.op = ALU_SUB;
                        OP_MUL:  alu_req.op = ALU_MUL;
                        OP_DIV:  alu_req.op = ALU_DIV;
                        OP_REM:  alu_req.op = ALU_REM;
                        default: alu_req.op = ALU_ADD;
                     endcase
                     state_in = S_EXE;
                  end
               end
               default: ;
            endcase
         end
         S_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m2[AW-1:0];
            state_in = S_FIN;
         end
         S_EXE: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[AW-1:0];
               wr_data  = alu_result;
               state_in = S_FIN;
            end
         end
         S_RLO: begin
            rd_addr  = lo_ff;
            state_in = S_RHI;
         end
         S_RHI: begin
            t_in     = rd_data_ff;
            rd_addr  = hi_ff;
            state_in = S_WLO;
         end
         S_WLO: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data_ff;
            state_in = S_WHI;
         end
         S_WHI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            lo_in    = lo_ff + 1'b1;
            hi_in    = hi_ff - 1'b1;
            state_in = (lo_ff + 1'b1 < hi_ff - 1'b1) ? S_RLO : S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (st_ff == ST_OK) begin
                  case (op_ff) inside
                     OP_PUSH, OP_DUP: cnt_in = cnt_ff + 1'b1;
                     OP_POP, OP_EMITN, OP_EMITC, OP_SUB, OP_ADD, OP_MUL, OP_DIV,
                     OP_REM: cnt_in = cnt_m1;
                     OP_CLEAR: cnt_in = '0;
                     default: ;
                  endcase
               end
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_depth_in = cnt_in;
               rsp_st_in    = st_ff;
               rsp_kind_in  = KIND_NONE;
               if (st_ff == ST_OK && op_ff == OP_EMITN) rsp_kind_in = KIND_NUM;
               if (st_ff == ST_OK && op_ff == OP_EMITC) rsp_kind_in = KIND_CHAR;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) stack_mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= stack_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      pv_ff        <= pv_in;
      t_ff         <= t_in;
      res_ff       <= res_in;
      st_ff        <= st_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_stack_depth  = rsp_depth_ff;
   assign rsp_emit_kind    = rsp_kind_ff;
   assign rsp_status       = rsp_st_ff;

`include "stack_machine_alu_macros.svh"

   `SMA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(STACK_DEPTH))
   `SMA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, state_ff != S_IDLE)
   `SMA_ASSERT_IMP(a_err_quiet, rsp_valid_ff && rsp_st_ff != ST_OK, rsp_kind_ff == KIND_NONE && rsp_res_ff == '0)
   `SMA_ASSERT_IMP(a_alu_done_exe, alu_done, state_ff == S_EXE)
endmodule

// ----- tb/stack_machine_alu_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_alu_tb
// Self-checking bench for the stack machine: a directed table of instruction
// words, a full-stack pass and constrained-by-hand random traffic. Each
// response word is checked against its typed table entry or a behavioral stack model.
// ----------------------------------------------------------------------------
module stack_machine_alu_tb;
   import sma_pkg::*;

   localparam int DEPTH = 256;
   localparam logic [3:0] OP_UNUSED = 4'd15;

   typedef struct {
      logic [31:0] value;
      logic [8:0]  depth;
      logic [1:0]  kind;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct {
      logic [3:0]   op;
      logic [31:0]  pv;
      bit           typed;
      rsp_word_type exp;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_opcode;
   logic [31:0] req_push_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_value;
   logic [8:0]  rsp_stack_depth;
   logic [1:0]  rsp_emit_kind;
   logic [1:0]  rsp_status;

   stack_machine_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_push_value(req_push_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_stack_depth(rsp_stack_depth),
      .rsp_emit_kind(rsp_emit_kind), .rsp_status(rsp_status)
   );

   // model of the stack
   logic [31:0] stk_mem [DEPTH];
   int unsigned stk_cnt;

   rsp_word_type pending_rsp[$];
   int          errors = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          status_seen [4] = '{0, 0, 0, 0};
   int          burst_left = 0;
   bit          rx_steady = 1;
   int          rx_left = 0;

   function void exec_stack_op(input logic [3:0] op, input logic [31:0] pv,
                               output rsp_word_type r);
      logic [31:0] t, s, tmp;
      int unsigned lo, hi;
      r.value = '0;
      r.kind = KIND_NONE;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (stk_cnt >= DEPTH) r.status = ST_OVER;
            else begin
               stk_mem[stk_cnt] = pv;
               stk_cnt++;
            end
         end
         OP_POP, OP_EMITN, OP_EMITC: begin
            if (stk_cnt == 0) r.status = ST_UNDER;
            else begin
               stk_cnt--;
               r.value = stk_mem[stk_cnt];
               r.kind = (op == OP_EMITN) ? KIND_NUM : (op == OP_EMITC) ? KIND_CHAR : KIND_NONE;
            end
         end
         OP_ROT: begin
            if (stk_cnt >= 2) begin
               lo = 0;
               hi = stk_cnt - 1;
               while (lo < hi) begin
                  tmp = stk_mem[lo];
                  stk_mem[lo] = stk_mem[hi];
                  stk_mem[hi] = tmp;
                  lo++;
                  hi--;
               end
            end
         end
         OP_DUP: begin
            if (stk_cnt == 0) r.status = ST_UNDER;
            else if (stk_cnt >= DEPTH) r.status = ST_OVER;
            else begin
               stk_mem[stk_cnt] = stk_mem[stk_cnt-1];
               stk_cnt++;
            end
         end
         OP_SWAP: begin
            if (stk_cnt < 2) r.status = ST_UNDER;
            else begin
               tmp = stk_mem[stk_cnt-1];
               stk_mem[stk_cnt-1] = stk_mem[stk_cnt-2];
               stk_mem[stk_cnt-2] = tmp;
            end
         end
         OP_SUB, OP_ADD, OP_MUL, OP_DIV, OP_REM: begin
            if (stk_cnt < 2) r.status = ST_UNDER;
            else begin
               t = stk_mem[stk_cnt-1];
               s = stk_mem[stk_cnt-2];
               if ((op == OP_DIV || op == OP_REM) && s == 0) r.status = ST_DIVZ;
               else begin
                  case (op)
                     OP_SUB:  tmp = t - s;
                     OP_ADD:  tmp = t + s;
                     OP_MUL:  tmp = t * s;
                     OP_DIV:  tmp = t / s;
                     default: tmp = t % s;
                  endcase
                  stk_cnt--;
                  stk_mem[stk_cnt-1] = tmp;
               end
            end
         end
         OP_PEEK: begin
            if (stk_cnt == 0) r.status = ST_UNDER;
            else r.value = stk_mem[stk_cnt-1];
         end
         OP_SIZE: r.value = stk_cnt;
         OP_CLEAR: begin
            if (stk_cnt == 0) r.status = ST_UNDER;
            else stk_cnt = 0;
         end
         default: ;
      endcase
      r.depth = stk_cnt[8:0];
   endfunction

   function rsp_word_type mk(input logic [31:0] v, input int d, input logic [1:0] k,
                             input logic [1:0] st);
      mk.value = v;
      mk.depth = d[8:0];
      mk.kind = k;
      mk.status = st;
   endfunction

   function logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: long steady stretches alternating with random stalls
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_steady <= $urandom_range(0, 2) == 0;
         rx_left <= $urandom_range(5, 60);
      end else rx_left <= rx_left - 1;
      rsp_ready <= rx_steady ? 1'b1 : ($urandom_range(0, 2) != 0);
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word value=%h depth=%0d kind=%0d status=%0d",
                     $realtime, rsp_result_value, rsp_stack_depth, rsp_emit_kind,
                     rsp_status);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            words_checked++;
            status_seen[rsp_status]++;
            if (rsp_result_value !== e.value || rsp_stack_depth !== e.depth ||
                rsp_emit_kind !== e.kind || rsp_status !== e.status) begin
               $display("%0t: mismatch expected value=%h depth=%0d kind=%0d status=%0d",
                        $realtime, e.value, e.depth, e.kind, e.status);
               $display("%0t:          actual   value=%h depth=%0d kind=%0d status=%0d",
                        $realtime, rsp_result_value, rsp_stack_depth, rsp_emit_kind,
                        rsp_status);
               errors++;
            end
         end
      end
   end

   task send(input logic [3:0] op, input logic [31:0] pv, input bit typed,
             input rsp_word_type exp);
      rsp_word_type p;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_push_value <= pv;
      do @(posedge clock); while (!req_ready);
      exec_stack_op(op, pv, p);
      pending_rsp.push_back(typed ? exp : p);
      words_sent++;
      // bursts of random length, random gaps between them
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 1)) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else burst_left--;
   endtask

   task send_op(input logic [3:0] op, input logic [31:0] pv);
      send(op, pv, 1'b0, mk(0, 0, KIND_NONE, ST_OK));
   endtask

   stim_row_type dir_rows[$];

   initial begin
      logic [3:0] op;
      int         n;
      int         cnt_rand;
      req_valid = 0;
      req_opcode = OP_PUSH;
      req_push_value = '0;
      rsp_ready = 0;
      reset = 1;
      stk_cnt = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      dir_rows = '{
         '{OP_POP,    32'd0,        1, mk(0, 0, KIND_NONE, ST_UNDER)},
         '{OP_EMITN,  32'd0,        1, mk(0, 0, KIND_NONE, ST_UNDER)},
         '{OP_EMITC,  32'd0,        1, mk(0, 0, KIND_NONE, ST_UNDER)},
         '{OP_PEEK,   32'd0,        1, mk(0, 0, KIND_NONE, ST_UNDER)},
         '{OP_CLEAR,  32'd0,        1, mk(0, 0, KIND_NONE, ST_UNDER)},
         '{OP_DUP,    32'd0,        1, mk(0, 0, KIND_NONE, ST_UNDER)},
         '{OP_SIZE,   32'hFFFF_FFFF, 1, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_ROT,    32'd0,        1, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_UNUSED, 32'hFFFF_FFFF, 1, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_PUSH,   32'd0,        1, mk(0, 1, KIND_NONE, ST_OK)},
         '{OP_SWAP,   32'd0,        1, mk(0, 1, KIND_NONE, ST_UNDER)},
         '{OP_ADD,    32'd0,        1, mk(0, 1, KIND_NONE, ST_UNDER)},
         '{OP_ROT,    32'd0,        1, mk(0, 1, KIND_NONE, ST_OK)},
         '{OP_PUSH,   32'hFFFF_FFFF, 1, mk(0, 2, KIND_NONE, ST_OK)},
         // divisor below the top is zero
         '{OP_DIV,    32'd0,        1, mk(0, 2, KIND_NONE, ST_DIVZ)},
         '{OP_REM,    32'd0,        1, mk(0, 2, KIND_NONE, ST_DIVZ)},
         '{OP_SWAP,   32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_PUSH,   32'd7,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_MUL,    32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_PUSH,   32'h8000_0001, 0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_DIV,    32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_DUP,    32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_SUB,    32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_EMITC,  32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)},
         '{OP_EMITN,  32'd0,        0, mk(0, 0, KIND_NONE, ST_OK)}
      };
      foreach (dir_rows[i])
         send(dir_rows[i].op, dir_rows[i].pv, dir_rows[i].typed, dir_rows[i].exp);

      // hold the sender until the pipe drains
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);

      // full stack: overflow on push and dup, rot over every entry
      if (stk_cnt != 0) send_op(OP_CLEAR, 0);
      repeat (DEPTH) send_op(OP_PUSH, pick_value());
      send_op(OP_PUSH, $urandom);
      send_op(OP_DUP, 0);
      send_op(OP_SIZE, 0);
      send_op(OP_ROT, 0);
      send_op(OP_PEEK, 0);
      send_op(OP_CLEAR, 0);

      // random traffic; pushes weighted so the stack stays populated
      cnt_rand = 0;
      while (cnt_rand < 270) begin
         n = $urandom_range(0, 99);
         if (n < 30 || (stk_cnt < 2 && n < 60)) op = OP_PUSH;
         else if (n < 32 && stk_cnt > 40) op = OP_CLEAR;
         else op = 4'($urandom_range(0, 15));
         send_op(op, pick_value());
         cnt_rand++;
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("covered %0d instruction words, %0d responses checked", words_sent,
               words_checked);
      $display("status mix: ok %0d, underflow %0d, overflow %0d, zero divisor %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0 && pending_rsp.size() == 0) $display("PASS stack_machine_alu");
      else $display("FAIL stack_machine_alu");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL stack_machine_alu");
      $finish;
   end
endmodule
